// File: rtl/dpfe_pkg.sv
// Shared constants and types for the downlink packet frequency extractor.
`timescale 1ns / 1ps
`default_nettype none

package dpfe_pkg;

	localparam int BYTE_W    = 8;
	localparam int GRP_W     = 4;
	localparam int CODE_W    = 12;
	localparam int POS_W     = 4;
	localparam int STORE_LEN = 10;   // packet bytes 0..9 are kept; 10 and 11 only feed the sums
	localparam int N_SLOTS   = 6;    // one sync slot followed by five channel slots
	localparam int N_CHAN    = 5;

	localparam logic [POS_W-1:0]  LAST_POS   = 4'd11;
	localparam logic [BYTE_W-1:0] TYPE_SYNC  = 8'h65;
	localparam logic [BYTE_W-1:0] TYPE_CHAN  = 8'h1C;
	localparam logic [BYTE_W-1:0] WRAP_LIMIT = 8'h40;
	localparam logic [CODE_W-1:0] WRAP_ADD   = 12'h100;
	localparam logic [GRP_W-1:0]  GRP_SYNC   = 4'h0;

	localparam logic KIND_SYNC = 1'b0;
	localparam logic KIND_CHAN = 1'b1;

	localparam int SLOT_SYNC = 0;

	// Results of one completed packet, drained one transaction at a time.
	typedef struct packed {
		logic [N_SLOTS-1:0]             mask;
		logic [GRP_W-1:0]               grp;
		logic [N_SLOTS-1:0][CODE_W-1:0] codes;
	} rec_t;

endpackage

`default_nettype wire

// File: rtl/dpfe_if.sv
// Channel interfaces for the frame byte stream and the frequency results.
`timescale 1ns / 1ps
`default_nettype none

interface dpfe_byte_if;
	import dpfe_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              frame_start;

	modport source(output valid, output frame_byte, output frame_start, input ready);
	modport sink(input valid, input frame_byte, input frame_start, output ready);
endinterface

interface dpfe_res_if;
	import dpfe_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [GRP_W-1:0]  group_number;
	logic [CODE_W-1:0] freq_code;
	logic              last;

	modport source(output valid, output kind, output group_number, output freq_code,
		output last, input ready);
	modport sink(input valid, input kind, input group_number, input freq_code,
		input last, output ready);
endinterface

`default_nettype wire

// File: rtl/dpfe_pkt.sv
// Packet assembly: byte input register, running checksums and result record build.
`timescale 1ns / 1ps
`default_nettype none

module dpfe_pkt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         byte_valid,
	output logic                         byte_ready,
	input  logic [dpfe_pkg::BYTE_W-1:0]  frame_byte,
	input  logic                         frame_start,
	input  logic                         busy,
	output logic                         load,
	output dpfe_pkg::rec_t               rec
);
	import dpfe_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] c0_q;
	logic [BYTE_W-1:0] c1_q;
	logic [BYTE_W-1:0] cur_q [STORE_LEN];

	logic              prev_present_q;
	logic [BYTE_W-1:0] prev_type_q;
	logic [BYTE_W-1:0] prev_b5_q;
	logic [BYTE_W-1:0] prev_c0_q;
	logic [BYTE_W-1:0] prev_c1_q;

	logic [POS_W-1:0]  pos_eff;
	logic              done;
	logic              stall;
	logic              fire;
	logic [BYTE_W-1:0] c0_n;
	logic [BYTE_W-1:0] c1_n;
	logic [BYTE_W-1:0] sum0_24;
	logic [BYTE_W-1:0] sum1_24;
	logic              sync_ok;
	logic              chan_ok;
	logic [63:0]       word_r;
	logic [CODE_W-1:0] sync_code;

	assign pos_eff    = start_s1 ? '0 : pos_q;
	assign done       = valid_s1 && (pos_eff == LAST_POS);
	// A completing byte waits while the previous packet's results are still draining.
	assign stall      = done && busy;
	assign fire       = valid_s1 && !stall;
	assign byte_ready = !stall;

	always_comb begin
		c0_n = ((pos_eff == '0) ? '0 : c0_q) + byte_s1;
		c1_n = ((pos_eff == '0) ? '0 : c1_q) + c0_n;
		// Sums over previous plus current packet: c1 gains twelve copies of the previous c0.
		sum0_24 = prev_c0_q + c0_n;
		sum1_24 = prev_c1_q + {prev_c0_q[4:0], 3'b000} + {prev_c0_q[5:0], 2'b00} + c1_n;
		sync_ok = prev_present_q && (prev_type_q == TYPE_SYNC) &&
			(sum0_24 == '0) && (sum1_24 == '0);
		chan_ok = (cur_q[0] == TYPE_CHAN) && (c0_n == '0) && (c1_n == '0);

		sync_code = {4'b0000, prev_b5_q};
		if (prev_b5_q <= WRAP_LIMIT) begin
			sync_code = sync_code | WRAP_ADD;
		end

		word_r = {cur_q[9], cur_q[8], cur_q[7], cur_q[6],
			cur_q[5], cur_q[4], cur_q[3], cur_q[2]};

		rec.grp                = cur_q[1][GRP_W-1:0];
		rec.codes[SLOT_SYNC]   = sync_code;
		rec.mask[SLOT_SYNC]    = sync_ok;
		for (int i = 0; i < N_CHAN; i++) begin
			rec.codes[i + 1] = word_r[59 - 12 * i -: CODE_W];
			rec.mask[i + 1]  = chan_ok && (word_r[59 - 12 * i -: CODE_W] != '0);
		end
	end

	assign load = fire && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			pos_q          <= '0;
			prev_present_q <= 1'b0;
		end else begin
			if (byte_valid && byte_ready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				pos_q <= done ? '0 : pos_eff + 1'b1;
			end
			if (load) begin
				prev_present_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1  <= frame_byte;
			start_s1 <= frame_start;
		end
		if (fire) begin
			c0_q <= c0_n;
			c1_q <= c1_n;
			for (int i = 0; i < STORE_LEN; i++) begin
				if (pos_eff == POS_W'(i)) begin
					cur_q[i] <= byte_s1;
				end
			end
		end
		if (load) begin
			prev_type_q <= cur_q[0];
			prev_b5_q   <= cur_q[5];
			prev_c0_q   <= c0_n;
			prev_c1_q   <= c1_n;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("packet byte position out of range");

	a_done_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (pos_q == '0) && prev_present_q)
		else $error("completed packet did not restart the byte position");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> busy && valid_s1)
		else $error("input stalled without pending results");

endmodule

`default_nettype wire

// File: rtl/dpfe_drain.sv
// Result record holder and output register: one frequency transaction per cycle while res_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module dpfe_drain (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  dpfe_pkg::rec_t               rec,
	output logic                         busy,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic                         kind,
	output logic [dpfe_pkg::GRP_W-1:0]   group_number,
	output logic [dpfe_pkg::CODE_W-1:0]  freq_code,
	output logic                         last
);
	import dpfe_pkg::*;

	logic [N_SLOTS-1:0]             mask_q;
	logic [GRP_W-1:0]               grp_q;
	logic [N_SLOTS-1:0][CODE_W-1:0] codes_q;

	logic              out_valid_q;
	logic              kind_q;
	logic [GRP_W-1:0]  grp_out_q;
	logic [CODE_W-1:0] code_out_q;
	logic              last_q;

	logic [N_SLOTS-1:0] sel;
	logic [N_SLOTS-1:0] rest;
	logic [CODE_W-1:0]  sel_code;
	logic               sel_sync;
	logic               take;

	assign busy = |mask_q;
	assign take = busy && (!out_valid_q || res_ready);

	// Lowest pending slot goes first: the sync result precedes the channel list.
	always_comb begin
		sel      = '0;
		sel_code = codes_q[SLOT_SYNC];
		for (int i = N_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel      = '0;
				sel[i]   = 1'b1;
				sel_code = codes_q[i];
			end
		end
		sel_sync = sel[SLOT_SYNC];
		rest     = mask_q & ~sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= rec.mask;
			end else if (take) begin
				mask_q <= rest;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q   <= rec.grp;
			codes_q <= rec.codes;
		end
		if (take) begin
			kind_q     <= sel_sync ? KIND_SYNC : KIND_CHAN;
			grp_out_q  <= sel_sync ? GRP_SYNC : grp_q;
			code_out_q <= sel_code;
			last_q     <= (rest == '0);
		end
	end

	assign res_valid    = out_valid_q;
	assign kind         = kind_q;
	assign group_number = grp_out_q;
	assign freq_code    = code_out_q;
	assign last         = last_q;

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy)
		else $error("new result record overwrote pending results");

	a_no_new_bits: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> (mask_q & ~$past(mask_q)) == '0)
		else $error("pending result mask gained bits without a load");

	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q && busy |=> out_valid_q)
		else $error("output register stayed empty with results pending");

endmodule

`default_nettype wire

// File: rtl/downlink_packet_freq_extractor_top.sv
// Top level of the downlink packet frequency extractor.
//
//  Channel   Dir   Payload                                      Transaction
//  frames    in    frame_byte[7:0], frame_start                 one frame byte
//  results   out   kind, group_number[3:0], freq_code[11:0],    one frequency code
//                  last
//
// One frame byte is accepted per cycle unless the input stalls. A byte is held in an input
// register, where it updates the packet position and the running checksums; the
// twelfth byte of a packet also builds a record of up to six results. Those leave
// through the output register one transaction per cycle while the results channel is ready.
// The record enters the holder when the completing byte leaves the input register.
// Reset clears the byte position, the previous-packet flag and all valid state.
// The input stalls only when a packet completes while the previous packet's results
// are still waiting on the results channel.
`timescale 1ns / 1ps
`default_nettype none

module downlink_packet_freq_extractor_top (
	input  logic          clk,
	input  logic          arst_n,
	dpfe_byte_if.sink     frames,
	dpfe_res_if.source    results
);
	import dpfe_pkg::*;

	// Record handoff between packet assembly and the result drain.
	rec_t rec;
	logic load;
	logic busy;

	// Packet assembly checks a sync packet over itself and the packet that follows it,
	// so a sync result is released together with the next packet's channel results.
	dpfe_pkt u_pkt (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (frames.valid),
		.byte_ready  (frames.ready),
		.frame_byte  (frames.frame_byte),
		.frame_start (frames.frame_start),
		.busy        (busy),
		.load        (load),
		.rec         (rec)
	);

	// The drain emits the sync result first, then nonzero channel codes in order,
	// and marks the final transaction of each record with last.
	dpfe_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.rec          (rec),
		.busy         (busy),
		.res_valid    (results.valid),
		.res_ready    (results.ready),
		.kind         (results.kind),
		.group_number (results.group_number),
		.freq_code    (results.freq_code),
		.last         (results.last)
	);

endmodule

`default_nettype wire
